@@ rtl/dll_pkg.sv @@
// dll_pkg: shared types and codes for the doubly linked list engine
// operation and status codes, controller states, command and status structs
// no dependencies
package dll_pkg;

  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int NODE_W   = 6;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FN_APPEND     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PREPEND    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_INS_AFTER  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_INS_BEFORE = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DUMP       = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_WR_A,
    S_WR_B,
    S_RESP,
    S_WALK_RD,
    S_WALK_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic rd_links;
    logic wr_a;
    logic wr_b;
    logic rd_walk;
    logic walk_adv;
    logic res_upd;
    logic res_walk;
  } dll_cmd_t;

  typedef struct packed {
    logic ignore;
    logic err;
    logic is_dump;
    logic needs_read;
    logic out_free;
    logic walk_last;
  } dll_stat_t;

endpackage

@@ rtl/doubly_linked_list_engine.sv @@
// doubly_linked_list_engine: top level of the linked list engine
// depends on dll_pkg, dll_ctrl, dll_datapath (and dll_ram through it)
//
// Input channel in_*: one item carries an operation code, a value and a node
// number; it is taken when in_valid is high and in_stall is low. Result
// channel out_*: status, new node number, dumped value and a last flag, taken
// when out_valid is high and out_stall is low.
// Updates give one result: append and prepend pass through the check and the
// link-write states, delete and the inserts also read the links first, and
// errors go from the check straight to the result; the next item is taken
// the cycle after the result is loaded. A dump gives one result per element;
// each result waits on the registered read of the next-link and value stores
// for the element in hand. Codes six and seven give no result and free the input after the check.
// Reset empties the list, clears all live marks and restarts numbering at 1;
// the node stores are not cleared. While the receiver stalls, the result
// register holds its item and the engine waits at its next result, still
// accepting one new item if it was idle.
module doubly_linked_list_engine import dll_pkg::*; #(
  parameter int NODE_SLOTS = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [FUNC_W-1:0]         in_func,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [NODE_W-1:0]         in_node,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STATUS_W-1:0]       out_status,
  output logic [NODE_W-1:0]         out_new_node,
  output logic signed [VALUE_W-1:0] out_data_out,
  output logic                      out_last
);

  dll_cmd_t  cmd;
  dll_stat_t stat;

  dll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  dll_datapath #(
    .NODE_SLOTS (NODE_SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_func      (in_func),
    .in_value     (in_value),
    .in_node      (in_node),
    .cmd          (cmd),
    .stat         (stat),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_new_node (out_new_node),
    .out_data_out (out_data_out),
    .out_last     (out_last)
  );

endmodule

@@ rtl/dll_ram.sv @@
// dll_ram: generic single write port, single read port ram with registered read
// no dependencies
module dll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/dll_datapath.sv @@
// dll_datapath: node stores, list pointers, allocator and result register
// depends on dll_pkg and dll_ram
module dll_datapath import dll_pkg::*; #(
  parameter int NODE_SLOTS = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [FUNC_W-1:0]          in_func,
  input  logic signed [VALUE_W-1:0]  in_value,
  input  logic [NODE_W-1:0]          in_node,
  input  dll_cmd_t                   cmd,
  output dll_stat_t                  stat,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [STATUS_W-1:0]        out_status,
  output logic [NODE_W-1:0]          out_new_node,
  output logic signed [VALUE_W-1:0]  out_data_out,
  output logic                       out_last
);

  localparam int IDX_W  = $clog2(NODE_SLOTS);
  localparam int FREE_W = $clog2(NODE_SLOTS + 1);
  localparam logic [FREE_W-1:0] FULL_AT  = FREE_W'(NODE_SLOTS);
  localparam logic [NODE_W:0]   SLOTS_C  = (NODE_W + 1)'(NODE_SLOTS);
  localparam logic [IDX_W-1:0]  NULL_IDX = '0;

  logic [FUNC_W-1:0]     func_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [NODE_W-1:0]     k_r;
  logic [IDX_W-1:0]      head_r, tail_r, ptr_r, n_r;
  logic [FREE_W-1:0]     free_r;
  logic [NODE_SLOTS-1:0] live_r;
  logic [STATUS_W-1:0]   code_r;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [NODE_W-1:0]     out_new_node_r;
  logic [VALUE_W-1:0]    out_data_r;
  logic                  out_last_r;

  logic [IDX_W-1:0]      k_idx;
  logic                  k_ok, full, alloc_op;
  logic [STATUS_W-1:0]   code;

  logic                  nx_we, pv_we, val_we, nx_re, val_re;
  logic [IDX_W-1:0]      nx_wa, pv_wa, nx_ra;
  logic [IDX_W-1:0]      nx_wd, pv_wd;
  logic [IDX_W-1:0]      nx_rd, pv_rd;
  logic [DATA_WIDTH-1:0] val_rd;

  dll_ram #(.WIDTH(IDX_W), .DEPTH(NODE_SLOTS)) u_next (
    .clk(clk), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
    .rd_en(nx_re), .rd_addr(nx_ra), .rd_data(nx_rd)
  );

  dll_ram #(.WIDTH(IDX_W), .DEPTH(NODE_SLOTS)) u_prev (
    .clk(clk), .wr_en(pv_we), .wr_addr(pv_wa), .wr_data(pv_wd),
    .rd_en(cmd.rd_links), .rd_addr(k_idx), .rd_data(pv_rd)
  );

  dll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODE_SLOTS)) u_value (
    .clk(clk), .wr_en(val_we), .wr_addr(n_r), .wr_data(val_r),
    .rd_en(val_re), .rd_addr(ptr_r), .rd_data(val_rd)
  );

  assign k_idx    = k_r[IDX_W-1:0];
  assign k_ok     = (k_r != '0) && ({1'b0, k_r} < SLOTS_C) && live_r[k_idx];
  assign full     = free_r >= FULL_AT;
  assign alloc_op = (func_r == FN_APPEND) || (func_r == FN_PREPEND) ||
                    (func_r == FN_INS_AFTER) || (func_r == FN_INS_BEFORE);

  always_comb begin
    code = ST_OK;
    priority if (func_r == FN_APPEND || func_r == FN_PREPEND) begin
      code = full ? ST_FULL : ST_OK;
    end else if (func_r == FN_DELETE) begin
      code = k_ok ? ST_OK : ST_BAD;
    end else if (func_r == FN_INS_AFTER || func_r == FN_INS_BEFORE) begin
      code = !k_ok ? ST_BAD : (full ? ST_FULL : ST_OK);
    end else if (func_r == FN_DUMP) begin
      code = (head_r == NULL_IDX) ? ST_EMPTY : ST_OK;
    end else begin
      code = ST_OK;
    end
  end

  always_comb begin
    stat.ignore     = func_r > FN_DUMP;
    stat.err        = code != ST_OK;
    stat.is_dump    = func_r == FN_DUMP;
    stat.needs_read = (func_r == FN_DELETE) || (func_r == FN_INS_AFTER) ||
                      (func_r == FN_INS_BEFORE);
    stat.out_free   = !out_valid_r || !out_stall;
    stat.walk_last  = nx_rd == NULL_IDX;
  end

  // read ports
  always_comb begin
    nx_re  = cmd.rd_links || cmd.rd_walk;
    nx_ra  = cmd.rd_walk ? ptr_r : k_idx;
    val_re = cmd.rd_walk;
  end

  // link writes, two phases per update
  always_comb begin
    nx_we  = 1'b0;
    nx_wa  = n_r;
    nx_wd  = NULL_IDX;
    pv_we  = 1'b0;
    pv_wa  = n_r;
    pv_wd  = NULL_IDX;
    val_we = cmd.wr_a && alloc_op;
    if (cmd.wr_a) begin
      unique case (func_r)
        FN_APPEND: begin
          pv_we = 1'b1;
          pv_wd = tail_r;
          nx_we = tail_r != NULL_IDX;
          nx_wa = tail_r;
          nx_wd = n_r;
        end
        FN_PREPEND: begin
          nx_we = 1'b1;
          nx_wd = head_r;
          pv_we = head_r != NULL_IDX;
          pv_wa = head_r;
          pv_wd = n_r;
        end
        FN_DELETE: begin
          nx_we = pv_rd != NULL_IDX;
          nx_wa = pv_rd;
          nx_wd = nx_rd;
          pv_we = nx_rd != NULL_IDX;
          pv_wa = nx_rd;
          pv_wd = pv_rd;
        end
        FN_INS_AFTER: begin
          nx_we = 1'b1;
          nx_wd = nx_rd;
          pv_we = 1'b1;
          pv_wd = k_idx;
        end
        FN_INS_BEFORE: begin
          pv_we = 1'b1;
          pv_wd = pv_rd;
          nx_we = 1'b1;
          nx_wd = k_idx;
        end
        default: begin
        end
      endcase
    end else if (cmd.wr_b) begin
      unique case (func_r)
        FN_APPEND: begin
          nx_we = 1'b1;
        end
        FN_PREPEND: begin
          pv_we = 1'b1;
        end
        FN_INS_AFTER: begin
          pv_we = nx_rd != NULL_IDX;
          pv_wa = nx_rd;
          pv_wd = n_r;
          nx_we = 1'b1;
          nx_wa = k_idx;
          nx_wd = n_r;
        end
        FN_INS_BEFORE: begin
          nx_we = pv_rd != NULL_IDX;
          nx_wa = pv_rd;
          nx_wd = n_r;
          pv_we = 1'b1;
          pv_wa = k_idx;
          pv_wd = n_r;
        end
        default: begin
        end
      endcase
    end
  end

  // item capture and scratch registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      val_r  <= DATA_WIDTH'(in_value);
      k_r    <= in_node;
    end
    if (cmd.check) begin
      code_r <= code;
      n_r    <= free_r[IDX_W-1:0];
      ptr_r  <= head_r;
    end else if (cmd.walk_adv) begin
      ptr_r  <= nx_rd;
    end
  end

  // list pointers, allocator and live marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NULL_IDX;
      tail_r <= NULL_IDX;
      free_r <= FREE_W'(1);
      live_r <= '0;
    end else if (cmd.wr_a) begin
      if (alloc_op) begin
        live_r[n_r] <= 1'b1;
        free_r      <= free_r + FREE_W'(1);
      end
      unique case (func_r)
        FN_APPEND: begin
          if (head_r == NULL_IDX) begin
            head_r <= n_r;
          end
          tail_r <= n_r;
        end
        FN_PREPEND: begin
          if (tail_r == NULL_IDX) begin
            tail_r <= n_r;
          end
          head_r <= n_r;
        end
        FN_DELETE: begin
          live_r[k_idx] <= 1'b0;
          if (pv_rd == NULL_IDX) begin
            head_r <= nx_rd;
          end
          if (nx_rd == NULL_IDX) begin
            tail_r <= pv_rd;
          end
        end
        FN_INS_AFTER: begin
          if (nx_rd == NULL_IDX) begin
            tail_r <= n_r;
          end
        end
        FN_INS_BEFORE: begin
          if (pv_rd == NULL_IDX) begin
            head_r <= n_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_upd || cmd.res_walk) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_upd) begin
      out_status_r   <= code_r;
      out_new_node_r <= (code_r == ST_OK && alloc_op) ? NODE_W'(n_r) : '0;
      out_data_r     <= '0;
      out_last_r     <= 1'b1;
    end else if (cmd.res_walk) begin
      out_status_r   <= ST_OK;
      out_new_node_r <= '0;
      out_data_r     <= VALUE_W'($signed(val_rd));
      out_last_r     <= nx_rd == NULL_IDX;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_new_node = out_new_node_r;
  assign out_data_out = out_data_r;
  assign out_last     = out_last_r;

endmodule

@@ rtl/dll_ctrl.sv @@
// dll_ctrl: sequencing state machine for the list engine
// depends on dll_pkg
module dll_ctrl import dll_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dll_stat_t stat,
  output dll_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = state_r != S_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        priority if (stat.ignore) begin
          state_nxt = S_IDLE;
        end else if (stat.err) begin
          state_nxt = S_RESP;
        end else if (stat.is_dump) begin
          state_nxt = S_WALK_RD;
        end else if (stat.needs_read) begin
          state_nxt = S_READ;
        end else begin
          state_nxt = S_WR_A;
        end
      end
      S_READ: begin
        cmd.rd_links = 1'b1;
        state_nxt    = S_WR_A;
      end
      S_WR_A: begin
        cmd.wr_a  = 1'b1;
        state_nxt = S_WR_B;
      end
      S_WR_B: begin
        cmd.wr_b  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.res_upd = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_WALK_RD: begin
        cmd.rd_walk = 1'b1;
        state_nxt   = S_WALK_EMIT;
      end
      S_WALK_EMIT: begin
        if (stat.out_free) begin
          cmd.res_walk = 1'b1;
          if (stat.walk_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.walk_adv = 1'b1;
            state_nxt    = S_WALK_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
